// ===== sv/backward_copy_word_realigner_unit_assert.svh =====
// assertion macros shared by the realigner checks
`ifndef BACKWARD_COPY_WORD_REALIGNER_UNIT_ASSERT_SVH
`define BACKWARD_COPY_WORD_REALIGNER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define BCWR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bcwr: same-cycle check failed");

// next-cycle implication, sampled on clk, off during rst
`define BCWR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bcwr: next-cycle check failed");

`endif

// ===== sv/bcwr_pkg.sv =====
// shared widths, codes and the write record of the backward copy realigner
package bcwr_pkg;

  localparam int WORD_BYTES = 8;
  localparam int LANE_BITS  = $clog2(WORD_BYTES);
  localparam int DATA_BITS  = 8 * WORD_BYTES;
  localparam int ADDR_BITS  = 48;
  localparam int IDX_BITS   = 45;
  localparam int COUNT_BITS = 32;
  // source words still expected, up to (count - 1 + source lane) / word + 1
  localparam int SWL_BITS   = COUNT_BITS - LANE_BITS + 1;
  // signed byte offset of a destination word inside the {carry, cur} window
  localparam int POS_BITS   = LANE_BITS + 3;

  typedef enum logic {
    KIND_CMD  = 1'b0,
    KIND_WORD = 1'b1
  } kind_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]   idx;
    logic [DATA_BITS-1:0]  data;
    logic [WORD_BYTES-1:0] be;
    logic                  last;
  } wr_t;

endpackage

// ===== sv/bcwr_if.sv =====
// request channel interfaces: command/source word feed and destination writes
interface bcwr_in_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [bcwr_pkg::ADDR_BITS-1:0]   src_addr;
  logic [bcwr_pkg::ADDR_BITS-1:0]   dst_addr;
  logic [bcwr_pkg::COUNT_BITS-1:0]  byte_count;
  logic [bcwr_pkg::DATA_BITS-1:0]   src_word;

  modport source (output valid, kind, src_addr, dst_addr, byte_count, src_word,
                  input ready);
  modport sink   (input valid, kind, src_addr, dst_addr, byte_count, src_word,
                  output ready);
endinterface

interface bcwr_out_if;
  logic                             valid;
  logic                             ready;
  logic [bcwr_pkg::IDX_BITS-1:0]    dst_word_index;
  logic [bcwr_pkg::DATA_BITS-1:0]   write_data;
  logic [bcwr_pkg::WORD_BYTES-1:0]  byte_enable;
  logic                             last;

  modport source (output valid, dst_word_index, write_data, byte_enable, last,
                  input ready);
  modport sink   (input valid, dst_word_index, write_data, byte_enable, last,
                  output ready);
endinterface

// ===== sv/backward_copy_word_realigner_unit.sv =====
// backward copy word realigner: shifts descending source words onto destination words
//
//  channel | dir | request carries
//  --------+-----+-----------------------------------------------------------
//  feed    | in  | kind, src_addr, dst_addr, byte_count, src_word
//  wr      | out | dst_word_index, write_data, byte_enable, last
//
// one request per cycle while wr.ready is high; a source word that completes two
// destination words waits for an empty write buffer, and the next request that
// yields a write waits for one of those two writes to drain.
// a write is registered in the write buffer after its request leaves the input register, and shows on wr from there.
// rst is synchronous and clears the control state; there is no clearing pass.
// with wr.ready low the write buffer fills and feed.ready drops, never combinationally
module backward_copy_word_realigner_unit (
  input logic        clk,
  input logic        rst,
  bcwr_in_if.sink    feed,
  bcwr_out_if.source wr
);

  localparam int LB = bcwr_pkg::LANE_BITS;
  localparam int PB = bcwr_pkg::POS_BITS;
  localparam logic [LB:0] WORD_CNT = (LB+1)'(bcwr_pkg::WORD_BYTES);
  localparam logic signed [PB-1:0] POS_WORD = PB'(bcwr_pkg::WORD_BYTES);

  // input register
  logic                              stg_v;
  logic                              stg_adv;
  logic                              stg_kind;
  logic [bcwr_pkg::ADDR_BITS-1:0]    stg_src;
  logic [bcwr_pkg::ADDR_BITS-1:0]    stg_dst;
  logic [bcwr_pkg::COUNT_BITS-1:0]   stg_n;
  logic [bcwr_pkg::DATA_BITS-1:0]    stg_word;

  // transfer state
  logic                              busy;
  logic [bcwr_pkg::DATA_BITS-1:0]    carry;
  logic [LB-1:0]                     shift_lane;
  logic signed [PB-1:0]              pbase;
  logic [bcwr_pkg::COUNT_BITS-1:0]   bytes_left;
  logic [LB-1:0]                     top_lane;
  logic [bcwr_pkg::IDX_BITS-1:0]     next_dst_word;
  logic [bcwr_pkg::SWL_BITS-1:0]     src_words_left;

  // write buffer
  bcwr_pkg::wr_t                     slot [2];
  bcwr_pkg::wr_t                     slot_next [2];
  logic [1:0]                        res_cnt;
  logic [1:0]                        res_cnt_next;

  // one destination write from the lane window
  function automatic bcwr_pkg::wr_t build_write(
    input logic [bcwr_pkg::IDX_BITS-1:0]  idx,
    input logic [LB-1:0]                  lane_hi,
    input logic [LB-1:0]                  lane_lo,
    input logic signed [PB-1:0]           pos,
    input logic [LB-1:0]                  sh,
    input logic [bcwr_pkg::DATA_BITS-1:0] cur,
    input logic [bcwr_pkg::DATA_BITS-1:0] prev,
    input logic                           last
  );
    bcwr_pkg::wr_t        w;
    logic [LB-1:0]        sl;
    logic signed [PB-1:0] p;
    w.idx  = idx;
    w.data = '0;
    w.be   = '0;
    w.last = last;
    for (int l = 0; l < bcwr_pkg::WORD_BYTES; l++) begin
      sl = LB'(l) + sh;
      p  = pos + PB'(l);
      if (LB'(l) <= lane_hi && LB'(l) >= lane_lo) begin
        w.be[l] = 1'b1;
        // below the word boundary the byte is in the newest word
        w.data[8*l +: 8] = (p < POS_WORD) ? cur[8*sl +: 8] : prev[8*sl +: 8];
      end
    end
    return w;
  endfunction

  // command decode
  logic                              cmd_empty;
  logic [bcwr_pkg::COUNT_BITS-1:0]   nm1;
  logic [bcwr_pkg::ADDR_BITS-1:0]    end_addr;
  logic [bcwr_pkg::COUNT_BITS:0]     src_end;
  logic [bcwr_pkg::SWL_BITS-1:0]     swl_init;
  logic signed [PB-1:0]              pbase_init;
  bcwr_pkg::wr_t                     empty_w;

  always_comb begin
    cmd_empty  = (stg_n == '0) || (stg_src == stg_dst);
    nm1        = stg_n - bcwr_pkg::COUNT_BITS'(1);
    end_addr   = stg_dst + bcwr_pkg::ADDR_BITS'(nm1);
    src_end    = {1'b0, nm1} + (bcwr_pkg::COUNT_BITS+1)'(stg_src[LB-1:0]);
    swl_init   = bcwr_pkg::SWL_BITS'(src_end >> LB) + bcwr_pkg::SWL_BITS'(1);
    pbase_init = $signed(PB'(src_end[LB-1:0])) - $signed(PB'(end_addr[LB-1:0]));
    empty_w.idx  = bcwr_pkg::IDX_BITS'(stg_dst[bcwr_pkg::ADDR_BITS-1:LB]);
    empty_w.data = '0;
    empty_w.be   = '0;
    empty_w.last = 1'b1;
  end

  // source word: up to two completed destination words
  logic                              js_zero;
  logic [LB:0]                       top_p1;
  logic                              o1_ok;
  logic                              o2_ok;
  logic                              last1;
  logic                              last2;
  logic [bcwr_pkg::COUNT_BITS-1:0]   bl1;
  logic [bcwr_pkg::COUNT_BITS-1:0]   bl2;
  logic [bcwr_pkg::COUNT_BITS-1:0]   bl_after;
  logic [LB-1:0]                     lo1;
  logic [LB-1:0]                     lo2;
  logic signed [PB-1:0]              pos2;
  logic signed [PB-1:0]              pbase_after;
  logic [bcwr_pkg::IDX_BITS-1:0]     idx2;
  logic [bcwr_pkg::IDX_BITS-1:0]     ndw_after;
  bcwr_pkg::wr_t                     w1;
  bcwr_pkg::wr_t                     w2;

  always_comb begin
    js_zero = (src_words_left == bcwr_pkg::SWL_BITS'(1));
    top_p1  = {1'b0, top_lane} + (LB+1)'(1);
    last1   = (bytes_left[bcwr_pkg::COUNT_BITS-1:LB+1] == '0) &&
              (bytes_left[LB:0] <= top_p1);
    bl1     = last1 ? '0 : bytes_left - bcwr_pkg::COUNT_BITS'(top_p1);
    lo1     = last1 ? LB'(top_p1 - bytes_left[LB:0]) : '0;
    o1_ok   = (stg_kind == bcwr_pkg::KIND_WORD) && busy && (bytes_left != '0) &&
              (js_zero || !pbase[PB-1]);
    pos2    = pbase - POS_WORD;
    last2   = (bl1[bcwr_pkg::COUNT_BITS-1:LB+1] == '0) && (bl1[LB:0] <= WORD_CNT);
    bl2     = last2 ? '0 : bl1 - bcwr_pkg::COUNT_BITS'(WORD_CNT);
    lo2     = last2 ? LB'(WORD_CNT - bl1[LB:0]) : '0;
    o2_ok   = o1_ok && !last1 && (js_zero || !pos2[PB-1]);
    idx2    = next_dst_word - bcwr_pkg::IDX_BITS'(1);
    w1 = build_write(next_dst_word, top_lane, lo1, pbase, shift_lane,
                     stg_word, carry, last1);
    w2 = build_write(idx2, {LB{1'b1}}, lo2, pos2, shift_lane,
                     stg_word, carry, last2);
    bl_after    = o2_ok ? bl2 : (o1_ok ? bl1 : bytes_left);
    ndw_after   = o2_ok ? idx2 - bcwr_pkg::IDX_BITS'(1) : (o1_ok ? idx2 : next_dst_word);
    pbase_after = o2_ok ? pos2 : (o1_ok ? pbase : pbase + POS_WORD);
  end

  // writes produced by the staged request
  logic [1:0]    nres;
  logic          res_free;
  logic          push;
  logic          pop;
  bcwr_pkg::wr_t new0;

  always_comb begin
    if (stg_kind == bcwr_pkg::KIND_CMD) begin
      nres = cmd_empty ? 2'd1 : 2'd0;
      new0 = empty_w;
    end else begin
      nres = 2'(o1_ok) + 2'(o2_ok);
      new0 = w1;
    end
    res_free = (nres == 2'd0) || (res_cnt == 2'd0) ||
               ((res_cnt == 2'd1) && (nres == 2'd1));
    stg_adv  = stg_v && res_free;
    push     = stg_adv && (nres != 2'd0);
  end

  assign feed.ready = !stg_v || stg_adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_v <= 1'b0;
    end else if (feed.ready) begin
      stg_v <= feed.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (feed.valid && feed.ready) begin
      stg_kind <= feed.kind;
      stg_src  <= feed.src_addr;
      stg_dst  <= feed.dst_addr;
      stg_n    <= feed.byte_count;
      stg_word <= feed.src_word;
    end
  end

  // transfer state update
  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      carry          <= '0;
      shift_lane     <= '0;
      pbase          <= '0;
      bytes_left     <= '0;
      top_lane       <= '0;
      next_dst_word  <= '0;
      src_words_left <= '0;
    end else if (stg_adv) begin
      case (stg_kind)
        bcwr_pkg::KIND_CMD: begin
          carry <= '0;
          if (cmd_empty) begin
            busy           <= 1'b0;
            bytes_left     <= '0;
            src_words_left <= '0;
          end else begin
            busy           <= 1'b1;
            bytes_left     <= stg_n;
            src_words_left <= swl_init;
            shift_lane     <= stg_src[LB-1:0] - stg_dst[LB-1:0];
            pbase          <= pbase_init;
            top_lane       <= end_addr[LB-1:0];
            next_dst_word  <= bcwr_pkg::IDX_BITS'(end_addr[bcwr_pkg::ADDR_BITS-1:LB]);
          end
        end
        bcwr_pkg::KIND_WORD: begin
          if (busy) begin
            carry         <= stg_word;
            bytes_left    <= bl_after;
            next_dst_word <= ndw_after;
            pbase         <= pbase_after;
            if (o1_ok) begin
              top_lane <= {LB{1'b1}};
            end
            if (js_zero || bl_after == '0) begin
              busy           <= 1'b0;
              src_words_left <= '0;
            end else begin
              src_words_left <= src_words_left - bcwr_pkg::SWL_BITS'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // write buffer: head in slot 0
  assign pop = (res_cnt != 2'd0) && wr.ready;

  always_comb begin
    logic [1:0] base;
    slot_next[0] = slot[0];
    slot_next[1] = slot[1];
    base = res_cnt;
    if (pop) begin
      slot_next[0] = slot[1];
      base = res_cnt - 2'd1;
    end
    if (push) begin
      if (base == 2'd0) begin
        slot_next[0] = new0;
        slot_next[1] = w2;
      end else begin
        slot_next[1] = new0;
      end
    end
    res_cnt_next = base + (push ? nres : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= 2'd0;
    end else begin
      res_cnt <= res_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    slot[0] <= slot_next[0];
    slot[1] <= slot_next[1];
  end

  assign wr.valid          = (res_cnt != 2'd0);
  assign wr.dst_word_index = slot[0].idx;
  assign wr.write_data     = slot[0].data;
  assign wr.byte_enable    = slot[0].be;
  assign wr.last           = slot[0].last;

endmodule

// ===== sv/bcwr_checker.sv =====
// port-level checks on the realigner write channel, bound to the top level
`include "backward_copy_word_realigner_unit_assert.svh"

module bcwr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            wr_valid,
  input logic                            wr_ready,
  input logic [bcwr_pkg::IDX_BITS-1:0]   wr_idx,
  input logic [bcwr_pkg::DATA_BITS-1:0]  wr_data,
  input logic [bcwr_pkg::WORD_BYTES-1:0] wr_be,
  input logic                            wr_last
);

  // a stalled write stays offered
  `BCWR_ASSERT_NEXT(a_wr_hold, wr_valid && !wr_ready, wr_valid)

  // a stalled write keeps its payload
  `BCWR_ASSERT_NEXT(a_wr_stable, wr_valid && !wr_ready, $stable({wr_idx, wr_data, wr_be, wr_last}))

  // a write with no lanes is the empty transfer marker
  `BCWR_ASSERT_NOW(a_empty_marker, wr_valid && (wr_be == '0), wr_last && (wr_data == '0))

  // every write but the final one reaches down to lane zero
  `BCWR_ASSERT_NOW(a_mid_low_lane, wr_valid && !wr_last, wr_be[0])

endmodule

bind backward_copy_word_realigner_unit bcwr_checker u_bcwr_checker (
  .clk      (clk),
  .rst      (rst),
  .wr_valid (wr.valid),
  .wr_ready (wr.ready),
  .wr_idx   (wr.dst_word_index),
  .wr_data  (wr.write_data),
  .wr_be    (wr.byte_enable),
  .wr_last  (wr.last)
);
